### hw/rtl/huffman_tree_decoder_top_assert.svh
// Assertion macros shared by the Huffman tree decoder RTL.
// No dependencies; taken in by `include.
`ifndef HUFFMAN_TREE_DECODER_TOP_ASSERT_SVH
`define HUFFMAN_TREE_DECODER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// combinational property checked at every rising clock edge
`define HTD_ASSERT_NOW(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// antecedent in one cycle implies consequent in the next
`define HTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define HTD_ASSERT_NOW(lbl, clk, rst_n, prop)
`define HTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/htd_pkg.sv
// Types and constants for the Huffman tree decoder.
// No dependencies.
package htd_pkg;

	localparam int IDX_W = 9;
	localparam int SYM_W = 8;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_BIT   = 2'd1,
		OP_EOM   = 2'd2
	} opcode_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [IDX_W-1:0] node_index;
		logic             node_is_leaf;
		logic [SYM_W-1:0] node_symbol;
		logic [IDX_W-1:0] left_child;
		logic [IDX_W-1:0] right_child;
		logic             code_bit;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             end_of_message;
	} result_t;

endpackage

### hw/rtl/huffman_tree_decoder_top.sv
// Huffman tree decoder top level: node table RAM, tree walk, result queue.
// A result passes through the stage 1 registers and the result queue before it is offered.
// Throughput: one item per cycle unless item_stall holds it; a code bit takes a single RAM read.
// A root register write stalls items through the fill1 and fill2 states while the root entry is fetched.
// Reset clears control state and the root; the node table is undefined until written.
// Depends on htd_pkg, htd_ram and huffman_tree_decoder_top_assert.svh.
`include "huffman_tree_decoder_top_assert.svh"

module huffman_tree_decoder_top #(
	parameter int NODE_COUNT  = 511,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  htd_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output htd_pkg::result_t            result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [htd_pkg::IDX_W-1:0]   cfg_data
);

	localparam int IDX_W = htd_pkg::IDX_W;
	localparam int SYM_W = htd_pkg::SYM_W;
	localparam int AW    = $clog2(NODE_COUNT);

	typedef struct packed {
		logic                   leaf;
		logic [SYMBOL_BITS-1:0] sym;
		logic [IDX_W-1:0]       left;
		logic [IDX_W-1:0]       right;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	// root register and cached entries
	logic [IDX_W-1:0] root_q;
	node_t            root_ent_q, root_ent_d;
	logic [IDX_W-1:0] cur_idx_q, cur_idx_d;
	node_t            cur_ent_q, cur_ent_d;
	logic             fill1_q, fill2_q, fill_oob_q;

	// stage 1
	logic             bit_s1, eom_s1, pend_s1;
	logic             cur_leaf_s1;
	logic [SYMBOL_BITS-1:0] cur_sym_s1;
	logic [IDX_W-1:0] nidx_s1;
	logic             oob_s1;

	// RAM
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [NODE_W-1:0] ram_rdata;

	// result queue
	htd_pkg::result_t fifo_q [3];
	logic [1:0]       wr_ptr_q, rd_ptr_q, occ_q;

	logic             in_acc, cfg_acc, is_wr, is_bit, is_eom, pop;
	logic             w_in_range, child_in, root_in;
	logic [IDX_W-1:0] eff_idx, child;
	node_t            eff_ent, nx, new_ent, fill_ent;
	logic             res_valid;
	htd_pkg::result_t res_data;

	assign cfg_ready  = ~fill1_q & ~fill2_q;
	assign cfg_acc    = cfg_valid & cfg_ready;
	assign item_stall = fill1_q | fill2_q |
		(({1'b0, occ_q} + {2'b00, (bit_s1 | eom_s1)}) > 3'd2);
	assign in_acc     = item_valid & ~item_stall;
	assign is_wr      = in_acc && (item.opcode == htd_pkg::OP_WRITE);
	assign is_bit     = in_acc && (item.opcode == htd_pkg::OP_BIT);
	assign is_eom     = in_acc && (item.opcode == htd_pkg::OP_EOM);

	assign w_in_range = item.node_index < NODE_COUNT;
	assign root_in    = root_q < NODE_COUNT;
	assign nx         = oob_s1 ? node_t'('0) : node_t'(ram_rdata);
	assign fill_ent   = fill_oob_q ? node_t'('0) : node_t'(ram_rdata);

	assign new_ent.leaf  = item.node_is_leaf;
	assign new_ent.sym   = SYMBOL_BITS'(item.node_symbol);
	assign new_ent.left  = item.left_child;
	assign new_ent.right = item.right_child;

	// node in force for the item at the input, after any walk resolving in stage 1
	always_comb begin
		eff_idx = cur_idx_q;
		eff_ent = cur_ent_q;
		if (pend_s1) begin
			if (nx.leaf) begin
				eff_idx = root_q;
				eff_ent = root_ent_q;
			end else begin
				eff_idx = nidx_s1;
				eff_ent = nx;
			end
		end
	end

	assign child    = item.code_bit ? eff_ent.right : eff_ent.left;
	assign child_in = child < NODE_COUNT;

	always_comb begin
		cur_idx_d  = eff_idx;
		cur_ent_d  = eff_ent;
		root_ent_d = root_ent_q;
		if (is_wr && w_in_range && (item.node_index == eff_idx)) begin
			cur_ent_d = new_ent;
		end
		if (is_wr && w_in_range && (item.node_index == root_q)) begin
			root_ent_d = new_ent;
		end
		if ((is_bit && eff_ent.leaf) || is_eom) begin
			cur_idx_d = root_q;
			cur_ent_d = root_ent_q;
		end
		if (fill2_q) begin
			cur_idx_d  = root_q;
			cur_ent_d  = fill_ent;
			root_ent_d = fill_ent;
		end
	end

	assign ram_we    = is_wr && w_in_range;
	assign ram_waddr = AW'(item.node_index);
	assign ram_re    = fill1_q ? root_in : (is_bit && !eff_ent.leaf && child_in);
	assign ram_raddr = fill1_q ? AW'(root_q) : AW'(child);

	htd_ram #(
		.WIDTH (NODE_W),
		.DEPTH (NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (new_ent),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q     <= '0;
			root_ent_q <= '0;
			cur_idx_q  <= '0;
			cur_ent_q  <= '0;
			fill1_q    <= 1'b0;
			fill2_q    <= 1'b0;
			bit_s1     <= 1'b0;
			eom_s1     <= 1'b0;
			pend_s1    <= 1'b0;
		end else begin
			if (cfg_acc) begin
				root_q <= cfg_data;
			end
			fill1_q    <= cfg_acc;
			fill2_q    <= fill1_q;
			root_ent_q <= root_ent_d;
			cur_idx_q  <= cur_idx_d;
			cur_ent_q  <= cur_ent_d;
			bit_s1     <= is_bit;
			eom_s1     <= is_eom;
			pend_s1    <= is_bit && !eff_ent.leaf;
		end
	end

	always_ff @(posedge clk) begin
		if (fill1_q) begin
			fill_oob_q <= !root_in;
		end
		cur_leaf_s1 <= eff_ent.leaf;
		cur_sym_s1  <= eff_ent.sym;
		nidx_s1     <= child;
		oob_s1      <= !child_in;
	end

	// stage 1 result
	assign res_valid = eom_s1 | (bit_s1 & (cur_leaf_s1 | (pend_s1 & nx.leaf)));
	assign res_data.end_of_message = eom_s1;
	assign res_data.symbol = eom_s1 ? '0 :
		(cur_leaf_s1 ? SYM_W'(cur_sym_s1) : SYM_W'(nx.sym));

	// three-entry result queue
	assign pop          = result_valid & ~result_stall;
	assign result_valid = occ_q != 2'd0;
	assign result       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= (wr_ptr_q == 2'd2) ? 2'd0 : wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == 2'd2) ? 2'd0 : rd_ptr_q + 2'd1;
			end
			occ_q <= occ_q + {1'b0, res_valid} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			fifo_q[wr_ptr_q] <= res_data;
		end
	end

	`HTD_ASSERT_NOW(a_queue_no_overflow, clk, arst_n, !(res_valid && occ_q == 2'd3 && !pop))
	`HTD_ASSERT_NEXT(a_fill_sequence, clk, arst_n, fill1_q, fill2_q && $stable(root_q))
	`HTD_ASSERT_NEXT(a_empty_stays_idle, clk, arst_n, occ_q == 2'd0 && !res_valid, !result_valid)
	`HTD_ASSERT_NOW(a_marker_zero_symbol, clk, arst_n,
		!(result_valid && result.end_of_message && result.symbol != '0))

endmodule

### hw/rtl/htd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htd_ram #(
	parameter int WIDTH = 27,
	parameter int DEPTH = 511
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### test/testbench.sv
// Testbench for the Huffman tree decoder: builds code trees in the node table, walks them with
// random bit streams under random idling and checks every decoded symbol against a local model.
// Depends on htd_pkg and huffman_tree_decoder_top.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import htd_pkg::*;

	localparam int NODE_COUNT = 511;
	localparam int IDLE_LIMIT = 2000;
	localparam int ITEM_TARGET = 1350;
	localparam int LONG_HOLD = 300;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [IDX_W-1:0] NO_NODE = 9'h1FF;

	typedef struct packed {
		logic             leaf;
		logic [SYM_W-1:0] sym;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
	} tree_node_t;

	class decode_scoreboard;
		tree_node_t node_table[NODE_COUNT];
		bit written[NODE_COUNT];
		logic [IDX_W-1:0] root_index = '0;
		logic [IDX_W-1:0] walk_node = '0;
		result_t pending_symbols[$];
		int mismatches = 0;

		function tree_node_t fetch(logic [IDX_W-1:0] idx);
			if (idx < NODE_COUNT) return node_table[idx];
			return '0;
		endfunction

		function bit known(logic [IDX_W-1:0] idx);
			return (idx >= NODE_COUNT) || written[idx];
		endfunction

		function void emit(logic [SYM_W-1:0] sym, logic eom);
			result_t r;
			r.symbol = sym;
			r.end_of_message = eom;
			pending_symbols.push_back(r);
		endfunction

		function void set_root(logic [IDX_W-1:0] idx);
			root_index = idx;
			walk_node = idx;
		endfunction

		// true when a code bit of this value reads only written or out-of-range entries
		function bit bit_is_safe(logic b);
			tree_node_t cur;
			if (!known(walk_node)) return 0;
			cur = fetch(walk_node);
			if (cur.leaf) return 1;
			return known(b ? cur.right : cur.left);
		endfunction

		function void note_item(item_t it);
			tree_node_t cur, nx;
			logic [IDX_W-1:0] nxt;
			case (it.opcode)
				OP_WRITE: begin
					if (it.node_index < NODE_COUNT) begin
						node_table[it.node_index] = {it.node_is_leaf, it.node_symbol,
							it.left_child, it.right_child};
						written[it.node_index] = 1'b1;
					end
				end
				OP_BIT: begin
					cur = fetch(walk_node);
					if (cur.leaf) begin
						emit(cur.sym, 1'b0);
						walk_node = root_index;
					end else begin
						nxt = it.code_bit ? cur.right : cur.left;
						nx = fetch(nxt);
						if (nx.leaf) begin
							emit(nx.sym, 1'b0);
							walk_node = root_index;
						end else begin
							walk_node = nxt;
						end
					end
				end
				OP_EOM: begin
					emit('0, 1'b1);
					walk_node = root_index;
				end
				default: ;
			endcase
		endfunction

		function void flag(string field, int want, int got);
			if (mismatches < 40)
				$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
			mismatches++;
		endfunction

		function void check_symbol(result_t got);
			result_t want;
			if (pending_symbols.size() == 0) begin
				if (mismatches < 40)
					$display("%0t: unexpected transaction, expected none actual %0h/%0b",
						$time, got.symbol, got.end_of_message);
				mismatches++;
				return;
			end
			want = pending_symbols.pop_front();
			if (got.symbol !== want.symbol) flag("symbol", want.symbol, got.symbol);
			if (got.end_of_message !== want.end_of_message)
				flag("end_of_message", want.end_of_message, got.end_of_message);
		endfunction

		function int pending_count();
			return pending_symbols.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_data = '0;

	decode_scoreboard board = new;

	int sent_items = 0;
	int burst_left = 0;
	int hold_requests = 0;
	int holds_granted = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int idle_cycles = 0;
	logic [IDX_W-1:0] tree_nodes[$];
	bit in_tree[NODE_COUNT];

	huffman_tree_decoder_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic item_t random_item();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[$bits(item_t)-1:0];
	endfunction

	function automatic item_t make_item(logic [1:0] op, logic [IDX_W-1:0] idx, logic leaf,
			logic [SYM_W-1:0] sym, logic [IDX_W-1:0] l, logic [IDX_W-1:0] r, logic b);
		item_t it;
		it.opcode = op;
		it.node_index = idx;
		it.node_is_leaf = leaf;
		it.node_symbol = sym;
		it.left_child = l;
		it.right_child = r;
		it.code_bit = b;
		return it;
	endfunction

	task automatic send_item(input item_t it);
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		board.note_item(it);
	endtask

	task automatic offer(input item_t it);
		send_item(it);
		if (it.opcode != OP_UNUSED && !(it.opcode == OP_WRITE && it.node_index >= NODE_COUNT))
			sent_items++;
		if (burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
				: $urandom_range(1, 30);
		end else begin
			burst_left--;
		end
	endtask

	task automatic write_root(input logic [IDX_W-1:0] root);
		item_valid <= 1'b0;
		while (board.pending_count() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= root;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_root(root);
	endtask

	// pairs random subtrees until one root is left
	task automatic build_tree(output logic [IDX_W-1:0] root);
		int leaves, k, pick, sel;
		logic [IDX_W-1:0] idx, a, b;
		logic [IDX_W-1:0] pool[$];
		item_t it;
		sel = $urandom_range(0, 19);
		if (sel == 0) leaves = 1;
		else if (sel == 1) leaves = $urandom_range(20, 64);
		else leaves = $urandom_range(2, 8);
		tree_nodes.delete();
		in_tree = '{default: 1'b0};
		for (k = 0; k < 2 * leaves - 1; k++) begin
			do idx = IDX_W'($urandom_range(0, NODE_COUNT - 1)); while (in_tree[idx]);
			in_tree[idx] = 1'b1;
			tree_nodes.push_back(idx);
		end
		for (k = 0; k < leaves; k++) begin
			it = random_item();
			it.opcode = OP_WRITE;
			it.node_index = tree_nodes[k];
			it.node_is_leaf = 1'b1;
			offer(it);
			pool.push_back(tree_nodes[k]);
		end
		for (k = leaves; k < 2 * leaves - 1; k++) begin
			pick = $urandom_range(0, pool.size() - 1);
			a = pool[pick];
			pool.delete(pick);
			pick = $urandom_range(0, pool.size() - 1);
			b = pool[pick];
			pool.delete(pick);
			it = random_item();
			it.opcode = OP_WRITE;
			it.node_index = tree_nodes[k];
			it.node_is_leaf = 1'b0;
			it.left_child = a;
			it.right_child = b;
			offer(it);
			pool.push_back(tree_nodes[k]);
		end
		root = pool[0];
	endtask

	task automatic decode_stream(input int count);
		int k, r;
		logic [IDX_W-1:0] idx;
		item_t it;
		for (k = 0; k < count; k++) begin
			it = random_item();
			r = $urandom_range(0, 99);
			if (r < 84) begin
				it.opcode = OP_BIT;
				if (!board.bit_is_safe(it.code_bit)) begin
					it.code_bit = ~it.code_bit;
					if (!board.bit_is_safe(it.code_bit)) it.opcode = OP_EOM;
				end
			end else if (r < 90) begin
				it.opcode = OP_EOM;
			end else if (r < 95) begin
				// rewrite inside the live tree, children stay in the tree
				it.opcode = OP_WRITE;
				it.node_index = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
				it.left_child = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
				it.right_child = tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
			end else if (r < 97) begin
				it.opcode = OP_UNUSED;
			end else begin
				it.opcode = OP_WRITE;
				if ($urandom_range(0, 1)) begin
					it.node_index = NO_NODE;
				end else begin
					do idx = IDX_W'($urandom_range(0, NODE_COUNT - 1)); while (in_tree[idx]);
					it.node_index = idx;
				end
			end
			offer(it);
		end
	endtask

	task automatic directed_items();
		offer(make_item(OP_WRITE, 9'd0, 1'b0, 8'hFF, 9'd1, 9'd510, 1'b0));
		offer(make_item(OP_WRITE, 9'd1, 1'b1, 8'h00, 9'd0, 9'd0, 1'b0));
		offer(make_item(OP_WRITE, 9'd510, 1'b1, 8'hFF, 9'd510, 9'd510, 1'b0));
		offer(make_item(OP_WRITE, NO_NODE, 1'b1, 8'hFF, NO_NODE, NO_NODE, 1'b1));
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b0));
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b1));
		offer(make_item(OP_WRITE, 9'd2, 1'b0, 8'h00, 9'd1, 9'd510, 1'b0));
		offer(make_item(OP_WRITE, 9'd3, 1'b0, 8'h00, NO_NODE, 9'd1, 1'b0));
		offer(make_item(OP_WRITE, 9'd0, 1'b0, 8'h00, 9'd2, 9'd3, 1'b0));
		// partial code dropped by end of message
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b0));
		offer(make_item(OP_EOM, '0, 1'b0, '0, '0, '0, 1'b0));
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b0));
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b1));
		// walk through the out-of-range child back to entry 0
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b1));
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b0));
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b1));
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b1));
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b1));
		// current node turned into a leaf under the walk
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b0));
		offer(make_item(OP_WRITE, 9'd2, 1'b1, 8'h5A, 9'd0, 9'd0, 1'b0));
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b1));
		offer(make_item(OP_UNUSED, 9'd5, 1'b1, 8'hA5, 9'd7, 9'd9, 1'b1));
		offer(make_item(OP_EOM, '0, 1'b0, '0, '0, '0, 1'b0));
		// root that is itself a leaf
		write_root(9'd1);
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b0));
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b1));
		write_root(9'd510);
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b1));
		write_root(9'd0);
		offer(make_item(OP_BIT, '0, 1'b0, '0, '0, '0, 1'b0));
	endtask

	initial begin
		logic [IDX_W-1:0] root;
		int phase;
		phase = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		while (sent_items < ITEM_TARGET) begin
			phase++;
			build_tree(root);
			write_root(root);
			if (phase == 3) hold_requests++;
			decode_stream($urandom_range(30, 120));
		end
		item_valid <= 1'b0;
		while (board.pending_count() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("huffman_tree_decoder_top: match");
		else
			$display("huffman_tree_decoder_top: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		if (holds_granted != hold_requests) begin
			holds_granted = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 80);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= 1'($urandom_range(0, 1));
				default: result_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) board.check_symbol(result);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles == IDLE_LIMIT) begin
					$display("huffman_tree_decoder_top: mismatch");
					$finish;
				end
			end
		end
	end

endmodule
